// ===== hw/rtl/scs_pkg.sv =====
// Package for the source comment and string scanner.
// Holds scan modes, result kinds, character codes, result structs and helpers.
// Depends on nothing.
package scs_pkg;

   localparam int MAX_STRING_LEN_DEFAULT = 1024;
   localparam int LEN_W = 11;
   localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_LVL_W = 3;

   typedef enum logic [3:0] {
      MODE_CODE  = 4'd0,
      MODE_SLASH = 4'd1,
      MODE_LINE  = 4'd2,
      MODE_BLOCK = 4'd3,
      MODE_BSTAR = 4'd4,
      MODE_STR   = 4'd5,
      MODE_ESC   = 4'd6,
      MODE_HEX1  = 4'd7,
      MODE_HEX2  = 4'd8
   } scs_mode_type;

   localparam logic [1:0] KIND_CODE  = 2'd0;
   localparam logic [1:0] KIND_BODY  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_EOS   = 2'd3;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [1:0]  kind;
      logic        separated;
      logic [15:0] line_number;
      logic        string_too_long;
      logic        last;
   } scs_result_type;

   // up to two results come out of one request
   typedef struct packed {
      logic [1:0]                count;
      scs_result_type [1:0]      res;
   } scs_push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
      return d[3:0];
   endfunction

endpackage

// ===== hw/rtl/scs_core.sv =====
// Scanner core: mode register, counters and the one-step decode logic.
// Produces up to two results per request. Depends on scs_pkg.
module scs_core
   import scs_pkg::*;
#(
   parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [7:0]   char_in,
   input  logic         end_of_source,
   output scs_push_type push
);

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_STRING_LEN);

   scs_mode_type     mode_ff, mode_in;
   logic             dq_ff, dq_in;
   logic [3:0]       hex_ff, hex_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [15:0]      line_ff, line_in;
   logic             gap_ff, gap_in;
   logic             sgap_ff, sgap_in;

   scs_result_type [1:0] res_v;
   logic [1:0]           n_v;
   logic                 do_code, code_gap, line_inc, tl;

   function automatic scs_result_type mk(input logic [7:0] c, input logic [1:0] k,
                                         input logic s, input logic t,
                                         input logic [15:0] ln);
      scs_result_type r;
      r.char_out = c;
      r.kind = k;
      r.separated = s;
      r.line_number = ln;
      r.string_too_long = t;
      r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      dq_in    = dq_ff;
      hex_in   = hex_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      gap_in   = gap_ff;
      sgap_in  = sgap_ff;
      res_v    = '0;
      n_v      = 2'd0;
      do_code  = 1'b0;
      code_gap = gap_ff;
      line_inc = 1'b0;
      tl       = (len_ff >= MaxLen);

      if (end_of_source) begin
         if (mode_ff == MODE_SLASH) begin
            res_v[0] = mk(CH_SLASH, KIND_CODE, sgap_ff, 1'b0, line_ff);
            n_v = 2'd1;
         end
         res_v[n_v[0]] = mk(8'h00, KIND_EOS, 1'b0, 1'b0, line_ff);
         n_v = n_v + 2'd1;
      end else begin
         case (mode_ff)
            MODE_SLASH: begin
               sgap_in = 1'b0;
               if (char_in == CH_SLASH || char_in == CH_DOLLAR) begin
                  mode_in = MODE_LINE;
                  gap_in  = 1'b1;
               end else if (char_in == CH_STAR) begin
                  mode_in = MODE_BLOCK;
                  gap_in  = 1'b1;
               end else begin
                  res_v[0] = mk(CH_SLASH, KIND_CODE, sgap_ff, 1'b0, line_ff);
                  n_v      = 2'd1;
                  gap_in   = 1'b0;
                  mode_in  = MODE_CODE;
                  code_gap = 1'b0;
                  do_code  = 1'b1;
               end
            end
            MODE_LINE: begin
               if (char_in == CH_LF) begin
                  line_inc = 1'b1;
                  mode_in  = MODE_CODE;
                  gap_in   = 1'b1;
               end
            end
            MODE_BLOCK, MODE_BSTAR: begin
               if (mode_ff == MODE_BSTAR && char_in == CH_SLASH) begin
                  mode_in = MODE_CODE;
                  gap_in  = 1'b1;
               end else begin
                  line_inc = (char_in == CH_LF);
                  mode_in  = (char_in == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
               end
            end
            MODE_STR: begin
               if (char_in == (dq_ff ? CH_DQUOTE : CH_SQUOTE)) begin
                  res_v[0] = mk(char_in, KIND_CLOSE, 1'b0, tl, line_ff);
                  n_v      = 2'd1;
                  len_in   = '0;
                  mode_in  = MODE_CODE;
               end else if (char_in == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  res_v[0] = mk(char_in, KIND_BODY, 1'b0, tl, line_ff);
                  n_v      = 2'd1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_STR;
               case (char_in)
                  CH_LO_T:   res_v[0] = mk(CH_TAB, KIND_BODY, 1'b0, tl, line_ff);
                  CH_LO_N:   res_v[0] = mk(CH_LF, KIND_BODY, 1'b0, tl, line_ff);
                  CH_LO_R:   res_v[0] = mk(CH_CR, KIND_BODY, 1'b0, tl, line_ff);
                  CH_BSLASH: res_v[0] = mk(CH_BSLASH, KIND_BODY, 1'b0, tl, line_ff);
                  CH_DQUOTE: res_v[0] = mk(CH_DQUOTE, KIND_BODY, 1'b0, tl, line_ff);
                  CH_SQUOTE: res_v[0] = mk(CH_SQUOTE, KIND_BODY, 1'b0, tl, line_ff);
                  CH_ZERO:   res_v[0] = mk(8'h00, KIND_BODY, 1'b0, tl, line_ff);
                  default:   res_v[0] = '0;
               endcase
               case (char_in)
                  CH_LO_T, CH_LO_N, CH_LO_R, CH_BSLASH, CH_DQUOTE, CH_SQUOTE,
                  CH_ZERO:          n_v = 2'd1;
                  CH_LO_X, CH_UP_X: mode_in = MODE_HEX1;
                  default:          n_v = 2'd0;
               endcase
            end
            MODE_HEX1: begin
               hex_in  = hex_val(char_in);
               mode_in = MODE_HEX2;
            end
            MODE_HEX2: begin
               res_v[0] = mk({hex_ff, hex_val(char_in)}, KIND_BODY, 1'b0, tl, line_ff);
               n_v      = 2'd1;
               mode_in  = MODE_STR;
            end
            default: begin
               mode_in = MODE_CODE;
               do_code = 1'b1;
            end
         endcase

         // every body byte bumps the saturating length
         if (n_v == 2'd1 && res_v[0].kind == KIND_BODY && len_ff < LEN_MAX)
            len_in = len_ff + LEN_W'(1);

         if (do_code) begin
            if (is_space(char_in)) begin
               gap_in   = 1'b1;
               line_inc = (char_in == CH_LF);
            end else if (char_in == CH_SLASH) begin
               sgap_in = code_gap;
               gap_in  = 1'b0;
               mode_in = MODE_SLASH;
            end else begin
               res_v[n_v[0]] = mk(char_in, KIND_CODE, code_gap, 1'b0, line_ff);
               n_v    = n_v + 2'd1;
               gap_in = 1'b0;
               if (char_in == CH_DQUOTE || char_in == CH_SQUOTE) begin
                  dq_in   = (char_in == CH_DQUOTE);
                  len_in  = '0;
                  mode_in = MODE_STR;
               end
            end
         end

         if (line_inc && line_ff != 16'hFFFF) line_in = line_ff + 16'd1;
      end

      if (n_v == 2'd1) res_v[0].last = 1'b1;
      if (n_v == 2'd2) res_v[1].last = 1'b1;

      if (end_of_source) begin
         mode_in = MODE_CODE;
         dq_in   = 1'b0;
         hex_in  = 4'd0;
         len_in  = '0;
         line_in = 16'd1;
         gap_in  = 1'b0;
         sgap_in = 1'b0;
      end
   end

   assign push.count = go ? n_v : 2'd0;
   assign push.res   = res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CODE;
         dq_ff   <= 1'b0;
         hex_ff  <= 4'd0;
         len_ff  <= '0;
         line_ff <= 16'd1;
         gap_ff  <= 1'b0;
         sgap_ff <= 1'b0;
      end else if (go) begin
         mode_ff <= mode_in;
         dq_ff   <= dq_in;
         hex_ff  <= hex_in;
         len_ff  <= len_in;
         line_ff <= line_in;
         gap_ff  <= gap_in;
         sgap_ff <= sgap_in;
      end
   end

`ifndef SYNTHESIS
   a_eos_resets: assert property (@(posedge clock) disable iff (reset)
      go && end_of_source |=> mode_ff == MODE_CODE && line_ff == 16'd1 && len_ff == '0)
      else $error("end of source did not restore reset state");
   a_pair_is_slash: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.res[0].kind == KIND_CODE && push.res[0].char_out == CH_SLASH)
      else $error("two results without a flushed slash");
   a_last_final: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.res[0].last && push.res[1].last)
      else $error("last flag not on final result");
`endif

endmodule

// ===== hw/rtl/scs_fifo.sv =====
// Result queue: takes zero, one or two results a cycle, gives one a cycle on pop.
// Small register array with read and write pointers. Depends on scs_pkg.
module scs_fifo
   import scs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  scs_push_type          push,
   input  logic                  pop,
   output scs_result_type        head,
   output logic                  not_empty,
   output logic [FIFO_LVL_W-1:0] level
);

   scs_result_type          mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_LVL_W-1:0]   lvl_ff, lvl_in;

   always_comb begin
      wr_in  = wr_ff + FIFO_PTR_W'(push.count);
      rd_in  = rd_ff + FIFO_PTR_W'(pop);
      lvl_in = lvl_ff + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ff] <= push.res[0];
      if (push.count == 2'd2) mem[wr_ff + FIFO_PTR_W'(1)] <= push.res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

   assign head      = mem[rd_ff];
   assign not_empty = (lvl_ff != '0);
   assign level     = lvl_ff;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("queue level out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         (4'(lvl_ff) + 4'(push.count) - 4'(pop)) <= 4'(FIFO_DEPTH))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> lvl_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/source_comment_and_string_scanner.sv =====
// Source comment and string scanner, top level.
// Flow: a request is held in the input register, decoded by the core when the
// queue has room, and its responses are written to the queue behind rsp_valid.
// Throughput: one request per cycle while the four-entry response queue has two
// free slots; a request that flushes a held slash gives two responses.
// Reset: synchronous; code mode, line 1, queue and input register empty.
module source_comment_and_string_scanner
   import scs_pkg::*;
#(
   parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_out,
   output logic [1:0]  rsp_kind,
   output logic        rsp_separated,
   output logic [15:0] rsp_line_number,
   output logic        rsp_string_too_long,
   output logic        rsp_last
);

   // input register stage
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_eos_ff;

   logic                  go;
   logic                  pop;
   scs_push_type          push;
   scs_result_type        head;
   logic [FIFO_LVL_W-1:0] level;

   // the decode step may push two responses, so it needs two free slots
   assign go        = in_valid_ff && (level <= FIFO_LVL_W'(FIFO_DEPTH - 2));
   assign req_ready = !in_valid_ff || go;
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
         in_eos_ff  <= req_end_of_source;
      end
   end

   scs_core #(
      .MAX_STRING_LEN(MAX_STRING_LEN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .char_in       (in_char_ff),
      .end_of_source (in_eos_ff),
      .push          (push)
   );

   scs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .level     (level)
   );

   assign rsp_char_out        = head.char_out;
   assign rsp_kind            = head.kind;
   assign rsp_separated       = head.separated;
   assign rsp_line_number     = head.line_number;
   assign rsp_string_too_long = head.string_too_long;
   assign rsp_last            = head.last;

endmodule
